// File: src/mvca_pkg.sv
// Shared types, codes and arithmetic helpers of the molecule velocity center accumulator.
package mvca_pkg;

    // Operation codes carried in func
    localparam logic [2:0] FUNC_ATOM  = 3'd0;
    localparam logic [2:0] FUNC_QMOL  = 3'd1;
    localparam logic [2:0] FUNC_LOAD  = 3'd2;
    localparam logic [2:0] FUNC_QTEN  = 3'd3;
    localparam logic [2:0] FUNC_CLEAR = 3'd4;

    // Configuration register indexes
    localparam logic CFG_GROUP    = 1'b0;
    localparam logic CFG_USE_MASS = 1'b1;

    // Velocity axes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam int          TENSOR_N  = 6;
    localparam logic [10:0] COUNT_MAX = 11'd2047;
    localparam logic [39:0] MASS_MAX  = 40'hFF_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]         func;
        logic [31:0]        group_mask;
        logic [10:0]        mol_id;
        logic [3:0]         species;
        logic [31:0]        mass_value;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [2:0]         tensor_index;
    } t_item;

    typedef struct packed {
        logic [39:0]        mass_total;
        logic signed [31:0] center_vx;
        logic signed [31:0] center_vy;
        logic signed [31:0] center_vz;
        logic signed [63:0] tensor_value;
        logic [10:0]        molecule_count;
        logic               id_overflow;
    } t_result;

    // One molecule entry of the accumulator memory
    typedef struct packed {
        logic               valid;
        logic [39:0]        mass;
        logic signed [63:0] mom_x;
        logic signed [63:0] mom_y;
        logic signed [63:0] mom_z;
    } t_entry;

    // Divider result beat
    typedef struct packed {
        logic               done;
        logic signed [31:0] value;
    } t_div_res;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_MOM,
        ST_TENS,
        ST_QLOAD,
        ST_QSTART,
        ST_QWAIT
    } t_state;

    // Saturating signed 64-bit add
    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                      input logic signed [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            sat_add64 = s[63:0];
        end
    endfunction

    // First and second axis of a tensor component (xx yy zz xy xz yz)
    function automatic logic [1:0] axis_a(input logic [2:0] comp);
        case (comp)
            3'd1:    axis_a = AXIS_Y;
            3'd2:    axis_a = AXIS_Z;
            3'd5:    axis_a = AXIS_Y;
            default: axis_a = AXIS_X;
        endcase
    endfunction

    function automatic logic [1:0] axis_b(input logic [2:0] comp);
        case (comp)
            3'd1:    axis_b = AXIS_Y;
            3'd3:    axis_b = AXIS_Y;
            3'd0:    axis_b = AXIS_X;
            default: axis_b = AXIS_Z;
        endcase
    endfunction

    function automatic logic signed [31:0] vel_of(input t_item it, input logic [1:0] axis);
        case (axis)
            AXIS_Y:  vel_of = it.vel_y;
            AXIS_Z:  vel_of = it.vel_z;
            default: vel_of = it.vel_x;
        endcase
    endfunction

endpackage

// File: src/mvca_div.sv
// Bit-serial divider: momentum over mass as a saturated signed Q16.16 center.
module mvca_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [63:0]        i_mom,
    input  logic [39:0]               i_mass,
    output mvca_pkg::t_div_res        o_res
);

    logic               r_busy;
    logic               r_done;
    logic signed [31:0] r_value;
    logic [4:0]         r_cnt;
    logic [40:0]        r_rem;
    logic [31:0]        r_low;
    logic [31:0]        r_quo;
    logic               r_neg;
    logic [39:0]        r_mass;

    logic [63:0] mag;
    logic [40:0] rem2;
    logic [40:0] rem_next;
    logic        qbit;
    logic [31:0] quo_next;
    logic        n_done;

    // Magnitude of the dividend
    assign mag = i_mom[63] ? (64'd0 - i_mom) : i_mom;

    // One restoring step
    always_comb begin
        rem2 = {r_rem[39:0], r_low[31]};
        qbit = rem2 >= {1'b0, r_mass};
        rem_next = qbit ? (rem2 - {1'b0, r_mass}) : rem2;
        quo_next = {r_quo[30:0], qbit};
    end

    // Done on a shortcut start or on the last restoring step
    assign n_done = i_start ? ((i_mass == 40'd0) || (mag >= {8'd0, i_mass, 16'd0}))
                            : (r_busy && r_cnt == 5'd31);

    // Clamp the quotient to the signed range and apply the sign
    function automatic logic signed [31:0] sat_center(input logic neg, input logic ovf,
                                                       input logic [31:0] q);
        if (!neg) begin
            sat_center = (ovf || q[31]) ? 32'h7FFF_FFFF : q;
        end else if (ovf || q >= 32'h8000_0000) begin
            sat_center = 32'h8000_0000;
        end else begin
            sat_center = 32'd0 - q;
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= n_done;
            if (i_start) begin
                r_neg  <= i_mom[63];
                r_mass <= i_mass;
                r_cnt  <= 5'd0;
                r_quo  <= 32'd0;
                r_rem  <= {1'b0, mag[55:16]};
                r_low  <= {mag[15:0], 16'd0};
                if (i_mass == 40'd0) begin
                    // Zero mass gives a zero center
                    r_value <= 32'sd0;
                end else if (mag >= {8'd0, i_mass, 16'd0}) begin
                    // Quotient beyond 32 bits: saturate at once
                    r_value <= sat_center(i_mom[63], 1'b1, 32'd0);
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= rem_next;
                r_quo <= quo_next;
                r_low <= {r_low[30:0], 1'b0};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy  <= 1'b0;
                    r_value <= sat_center(r_neg, 1'b0, quo_next);
                end
            end
        end
    end

    assign o_res.done  = r_done;
    assign o_res.value = r_value;

endmodule

// File: src/molecule_velocity_center_accumulator_unit.sv
// Top level: per-molecule mass/momentum accumulator with kinetic tensor and queries.
// Type load, out-of-group atom and bad id are taken in idle and leave busy low.
// Atom on a molecule: accept and read, open entry, three multiply steps, write back.
// Atom without molecule: six tensor terms in turn on the one shared multiplier. Tensor
// query: result in the cycle after start. Molecule query: one division per axis on the
// bit-serial divider (shortcut when mass is zero or center saturates). Results cannot stall.
// Reset sweeps the molecule memory (busy high); clear runs the same sweep.
module molecule_velocity_center_accumulator_unit #(
    parameter int MOLECULES  = 1024,
    parameter int ATOM_TYPES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  mvca_pkg::t_item       i_item,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [31:0]           i_cfg_data,
    output logic                  o_valid,
    output mvca_pkg::t_result     o_result
);

    localparam int AW = (MOLECULES > 1) ? $clog2(MOLECULES) : 1;
    localparam int TW = (ATOM_TYPES > 1) ? $clog2(ATOM_TYPES) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MOLECULES - 1);
    localparam logic [2:0] MOM_LAST  = 3'd4;
    localparam logic [2:0] TENS_LAST = 3'd5;
    localparam logic [2:0] COMP_LAST = 3'(mvca_pkg::TENSOR_N - 1);

    mvca_pkg::t_state r_state, n_state;

    logic [31:0]        r_group;
    logic               r_use_mass;
    logic [31:0]        r_tmass [ATOM_TYPES];
    logic signed [63:0] r_tensor [mvca_pkg::TENSOR_N];
    logic [10:0]        r_count;
    logic               r_ovf;

    mvca_pkg::t_item    r_item;
    logic [31:0]        r_m;
    logic [AW-1:0]      r_addr;
    logic [2:0]         r_step;
    logic [2:0]         r_comp;
    logic               r_qok;
    logic signed [63:0] r_prod;
    logic [63:0]        r_mag;
    logic               r_neg;
    logic [63:0]        r_lo;
    logic signed [63:0] r_term;
    mvca_pkg::t_entry   r_acc;
    mvca_pkg::t_entry   r_rd;
    logic signed [31:0] r_cx, r_cy;
    logic               r_valid;
    mvca_pkg::t_result  r_res;

    mvca_pkg::t_entry   mem [MOLECULES];

    // Input decode
    logic        accept;
    logic        counted;
    logic [16:0] id17;
    logic        id_zero;
    logic        in_range;
    logic [AW-1:0] in_addr;
    logic [7:0]  type8;
    logic        type_ok;
    logic [31:0] atom_m;

    assign accept   = start && !busy;
    assign counted  = (i_item.group_mask & r_group) != 32'd0;
    assign id17     = 17'(i_item.mol_id);
    assign id_zero  = id17 == 17'd0;
    assign in_range = !id_zero && (id17 <= 17'(MOLECULES));
    assign in_addr  = AW'(id17 - 17'd1);
    assign type8    = 8'(i_item.species);
    assign type_ok  = 9'(type8) < 9'(ATOM_TYPES);
    assign atom_m   = r_use_mass ? i_item.mass_value
                                 : (type_ok ? r_tmass[type8[TW-1:0]] : 32'd0);

    // Shared multiplier operands
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;

    always_comb begin
        mul_a = '0;
        mul_b = {1'b0, r_m};
        if (r_state == mvca_pkg::ST_MOM) begin
            case (r_step)
                3'd0:    mul_a = {r_item.vel_x[31], r_item.vel_x};
                3'd1:    mul_a = {r_item.vel_y[31], r_item.vel_y};
                default: mul_a = {r_item.vel_z[31], r_item.vel_z};
            endcase
        end else if (r_state == mvca_pkg::ST_TENS) begin
            case (r_step)
                3'd0: begin
                    mul_a = 33'(mvca_pkg::vel_of(r_item, mvca_pkg::axis_a(r_comp)));
                    mul_b = 33'(mvca_pkg::vel_of(r_item, mvca_pkg::axis_b(r_comp)));
                end
                3'd2:    mul_a = {1'b0, r_mag[31:0]};
                default: mul_a = {1'b0, r_mag[63:32]};
            endcase
        end
    end

    assign mul_p = mul_a * mul_b;

    // Tensor term assembly: floor of the signed Q48.48 product shifted by 32
    logic [63:0] t_q;
    logic [63:0] t_q_rnd;
    assign t_q     = r_prod + {32'd0, r_lo[63:32]};
    assign t_q_rnd = (r_neg && (r_lo[31:0] != 32'd0)) ? (t_q + 64'd1) : t_q;

    // Mass update of the open entry
    logic [40:0] mass_s;
    logic [39:0] mass_new;
    assign mass_s   = {1'b0, r_acc.mass} + 41'(r_m);
    assign mass_new = mass_s[40] ? mvca_pkg::MASS_MAX : mass_s[39:0];

    // Next value of the open entry during a molecule update
    mvca_pkg::t_entry n_acc;
    always_comb begin
        n_acc = r_acc;
        case (r_step)
            3'd0: begin
                // Open the entry: an unused one starts from zero
                n_acc       = r_rd.valid ? r_rd : '0;
                n_acc.valid = 1'b1;
            end
            3'd1: n_acc.mom_x = mvca_pkg::sat_add64(r_acc.mom_x, r_prod >>> 16);
            3'd2: n_acc.mom_y = mvca_pkg::sat_add64(r_acc.mom_y, r_prod >>> 16);
            3'd3: begin
                n_acc.mom_z = mvca_pkg::sat_add64(r_acc.mom_z, r_prod >>> 16);
                n_acc.mass  = mass_new;
            end
            default: ;
        endcase
    end

    // Divider
    logic               div_start;
    logic signed [63:0] div_mom;
    mvca_pkg::t_div_res div_res;

    assign div_start = r_state == mvca_pkg::ST_QSTART;
    always_comb begin
        case (r_comp)
            3'd0:    div_mom = r_acc.mom_x;
            3'd1:    div_mom = r_acc.mom_y;
            default: div_mom = r_acc.mom_z;
        endcase
    end

    mvca_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_mom   (div_mom),
        .i_mass  (r_acc.mass),
        .o_res   (div_res)
    );

    // Result beats of both query kinds
    mvca_pkg::t_result ten_res;
    mvca_pkg::t_result mol_res;
    logic              n_valid;

    always_comb begin
        ten_res                = '0;
        ten_res.molecule_count = r_count;
        ten_res.id_overflow    = r_ovf;
        if (i_item.tensor_index <= COMP_LAST) begin
            ten_res.tensor_value = r_tensor[i_item.tensor_index];
        end
        mol_res                = '0;
        mol_res.mass_total     = r_acc.mass;
        mol_res.center_vx      = r_cx;
        mol_res.center_vy      = r_cy;
        mol_res.center_vz      = div_res.value;
        mol_res.molecule_count = r_count;
        mol_res.id_overflow    = r_ovf;
    end

    assign n_valid = (r_state == mvca_pkg::ST_IDLE && start
                      && i_item.func == mvca_pkg::FUNC_QTEN)
                  || (r_state == mvca_pkg::ST_QWAIT && div_res.done && r_comp == 3'd2);

    // Memory ports
    logic             mem_we;
    logic             mem_re;
    mvca_pkg::t_entry mem_wdata;

    assign mem_we    = (r_state == mvca_pkg::ST_SWEEP)
                    || (r_state == mvca_pkg::ST_MOM && r_step == MOM_LAST);
    assign mem_wdata = (r_state == mvca_pkg::ST_SWEEP) ? '0 : r_acc;
    assign mem_re    = accept && in_range
                    && (i_item.func == mvca_pkg::FUNC_ATOM || i_item.func == mvca_pkg::FUNC_QMOL);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= mem[in_addr];
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mvca_pkg::ST_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mvca_pkg::ST_SWEEP: begin
                if (r_addr == LAST_ADDR) n_state = mvca_pkg::ST_IDLE;
            end
            mvca_pkg::ST_IDLE: begin
                if (start) begin
                    case (i_item.func)
                        mvca_pkg::FUNC_ATOM: begin
                            if (counted && id_zero) n_state = mvca_pkg::ST_TENS;
                            else if (counted && in_range) n_state = mvca_pkg::ST_MOM;
                        end
                        mvca_pkg::FUNC_QMOL:  n_state = mvca_pkg::ST_QLOAD;
                        mvca_pkg::FUNC_CLEAR: n_state = mvca_pkg::ST_SWEEP;
                        default: ;
                    endcase
                end
            end
            mvca_pkg::ST_MOM: begin
                if (r_step == MOM_LAST) n_state = mvca_pkg::ST_IDLE;
            end
            mvca_pkg::ST_TENS: begin
                if (r_step == TENS_LAST && r_comp == COMP_LAST) n_state = mvca_pkg::ST_IDLE;
            end
            mvca_pkg::ST_QLOAD:  n_state = mvca_pkg::ST_QSTART;
            mvca_pkg::ST_QSTART: n_state = mvca_pkg::ST_QWAIT;
            mvca_pkg::ST_QWAIT: begin
                if (div_res.done) begin
                    n_state = (r_comp == 3'd2) ? mvca_pkg::ST_IDLE : mvca_pkg::ST_QSTART;
                end
            end
            default: n_state = mvca_pkg::ST_IDLE;
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group    <= 32'd1;
            r_use_mass <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mvca_pkg::CFG_GROUP:    r_group    <= i_cfg_data;
                mvca_pkg::CFG_USE_MASS: r_use_mass <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Datapath and sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr  <= '0;
            r_step  <= 3'd0;
            r_comp  <= 3'd0;
            r_count <= 11'd0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
            for (int i = 0; i < ATOM_TYPES; i++) r_tmass[i] <= 32'd0;
            for (int i = 0; i < mvca_pkg::TENSOR_N; i++) r_tensor[i] <= 64'sd0;
        end else begin
            r_valid <= n_valid;
            r_prod  <= mul_p[63:0];
            case (r_state)
                mvca_pkg::ST_SWEEP: begin
                    if (r_addr != LAST_ADDR) r_addr <= r_addr + AW'(1);
                end
                mvca_pkg::ST_IDLE: begin
                    if (start) begin
                        r_item <= i_item;
                        r_m    <= atom_m;
                        r_step <= 3'd0;
                        r_comp <= 3'd0;
                        r_addr <= (i_item.func == mvca_pkg::FUNC_CLEAR) ? '0 : in_addr;
                        r_qok  <= in_range;
                        case (i_item.func)
                            mvca_pkg::FUNC_ATOM: begin
                                if (counted && !id_zero && !in_range) r_ovf <= 1'b1;
                            end
                            mvca_pkg::FUNC_LOAD: begin
                                if (type_ok) r_tmass[type8[TW-1:0]] <= i_item.mass_value;
                            end
                            mvca_pkg::FUNC_QTEN: begin
                                r_res <= ten_res;
                            end
                            mvca_pkg::FUNC_CLEAR: begin
                                r_count <= 11'd0;
                                for (int i = 0; i < mvca_pkg::TENSOR_N; i++) begin
                                    r_tensor[i] <= 64'sd0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                mvca_pkg::ST_MOM: begin
                    r_step <= r_step + 3'd1;
                    r_acc  <= n_acc;
                    if (r_step == 3'd3 && r_acc.mass == 40'd0 && mass_new != 40'd0
                        && r_count != mvca_pkg::COUNT_MAX) begin
                        r_count <= r_count + 11'd1;
                    end
                end
                mvca_pkg::ST_TENS: begin
                    case (r_step)
                        3'd1: begin
                            r_neg <= r_prod[63];
                            r_mag <= r_prod[63] ? (64'd0 - r_prod) : r_prod;
                        end
                        3'd3: r_lo   <= r_prod;
                        3'd4: r_term <= r_neg ? (64'd0 - t_q_rnd) : t_q_rnd;
                        default: ;
                    endcase
                    if (r_step == TENS_LAST) begin
                        r_tensor[r_comp] <= mvca_pkg::sat_add64(r_tensor[r_comp], r_term);
                        r_step <= 3'd0;
                        r_comp <= r_comp + 3'd1;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                mvca_pkg::ST_QLOAD: begin
                    r_acc <= (r_qok && r_rd.valid) ? r_rd : '0;
                end
                mvca_pkg::ST_QWAIT: begin
                    if (div_res.done) begin
                        r_comp <= r_comp + 3'd1;
                        case (r_comp)
                            3'd0: r_cx <= div_res.value;
                            3'd1: r_cy <= div_res.value;
                            default: begin
                                // Emit the molecule result beat
                                r_res <= mol_res;
                            end
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    assign busy     = r_state != mvca_pkg::ST_IDLE;
    assign o_valid  = r_valid;
    assign o_result = r_res;

    // A result beat follows a tensor query in idle or the last divide of a molecule query
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == mvca_pkg::ST_IDLE || $past(r_state) == mvca_pkg::ST_QWAIT))
        else $error("result beat from an unexpected state");

    // Only tensor queries give a beat straight from idle
    a_no_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.func != mvca_pkg::FUNC_QTEN) |=> !o_valid)
        else $error("result beat without a query");

    // Molecule write back closes the item
    a_wb_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mvca_pkg::ST_MOM && r_step == MOM_LAST) |=> r_state == mvca_pkg::ST_IDLE)
        else $error("molecule update did not finish after write back");

endmodule
